// ===== sv/window_peak_prominence_filter_macros.svh =====
// ---------------------------------------------------------------------------
// Window peak prominence filter: assertion macros
// Concurrent checks on the rising edge of clk, disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef WINDOW_PEAK_PROMINENCE_FILTER_MACROS_SVH
`define WINDOW_PEAK_PROMINENCE_FILTER_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every edge
`define WPPF_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("wppf: assertion failed");
// condition must never be true
`define WPPF_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
	else $error("wppf: forbidden condition seen");
`else
`define WPPF_ASSERT(lbl, prop)
`define WPPF_NEVER(lbl, cond)
`endif

`endif

// ===== sv/wppf_pkg.sv =====
// ---------------------------------------------------------------------------
// wppf_pkg
// Shared widths, constants, sequencer states and cell control for the
// window peak prominence filter.
// ---------------------------------------------------------------------------
package wppf_pkg;

	localparam int SAMPLE_W          = 17;
	localparam int QUOT_W            = SAMPLE_W - 1;
	localparam int CFG_W             = 6;
	localparam int BIT_CNT_W         = $clog2(SAMPLE_W);
	localparam int MAX_NEIGHBORS_DEF = 63;

	localparam logic [CFG_W-1:0]     NEIGHBORS_RESET = CFG_W'(24);
	localparam logic [BIT_CNT_W-1:0] BIT_LAST        = BIT_CNT_W'(SAMPLE_W - 1);
	// score of 1.0, for a peak whose neighbors are all zero
	localparam logic [SAMPLE_W-1:0]  SCORE_ONE       = SAMPLE_W'(65536);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_SCAN,
		ST_CMP,
		ST_DIV,
		ST_PUSH
	} state_t;

	typedef struct packed {
		logic shift;   // take the neighbor's sample
		logic clear;   // zero the sample
		logic setup;   // load window and center flags
		logic scan;    // rotate one bit and prune candidates
	} cell_ctrl_t;

endpackage

// ===== sv/wppf_channels.sv =====
// ---------------------------------------------------------------------------
// wppf channels
// Valid/ready channel interfaces for samples, results and configuration.
// ---------------------------------------------------------------------------
interface wppf_sample_if;
	logic                             valid;
	logic                             ready;
	logic [wppf_pkg::SAMPLE_W-1:0]    sample;
	logic                             end_of_stream;

	modport source (output valid, output sample, output end_of_stream, input ready);
	modport sink   (input valid, input sample, input end_of_stream, output ready);
endinterface

interface wppf_result_if;
	logic                             valid;
	logic                             ready;
	logic [wppf_pkg::SAMPLE_W-1:0]    score;
	logic                             final_res;

	modport source (output valid, output score, output final_res, input ready);
	modport sink   (input valid, input score, input final_res, output ready);
endinterface

interface wppf_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [wppf_pkg::CFG_W-1:0]       neighbors;

	modport source (output valid, output neighbors, input ready);
	modport sink   (input valid, input neighbors, output ready);
endinterface

// ===== sv/wppf_cell.sv =====
// ---------------------------------------------------------------------------
// wppf_cell
// One window position: holds a sample, shifts it to the next cell, and takes
// part in the MSB-first maximum search and center readout.
// ---------------------------------------------------------------------------
module wppf_cell #(
	parameter int IDX = 0,
	parameter int NW  = 6,
	parameter int IW  = 7
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  wppf_pkg::cell_ctrl_t          ctrl,
	input  logic [wppf_pkg::SAMPLE_W-1:0] prev_sample,
	input  logic [NW-1:0]                 center,
	input  logic [NW-1:0]                 nbr,
	input  logic                          any_cand,
	output logic [wppf_pkg::SAMPLE_W-1:0] sample,
	output logic                          cand_bit,
	output logic                          ctr_bit,
	output logic                          is_center
);

	localparam int W  = wppf_pkg::SAMPLE_W;
	localparam int XW = IW + 1;
	localparam logic [XW-1:0] POS = XW'(IDX);

	logic [W-1:0]  sample_q;
	logic          alive_q;
	logic          center_q;
	logic [XW-1:0] c_ext;
	logic [XW-1:0] n_ext;
	logic          in_win;
	logic          at_ctr;

	assign c_ext  = XW'(center);
	assign n_ext  = XW'(nbr);
	assign at_ctr = (POS == c_ext);
	assign in_win = !at_ctr && (POS + n_ext >= c_ext) && (POS <= c_ext + n_ext);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_q <= '0;
			alive_q  <= 1'b0;
			center_q <= 1'b0;
		end else begin
			if (ctrl.clear) begin
				sample_q <= '0;
			end else if (ctrl.shift) begin
				sample_q <= prev_sample;
			end else if (ctrl.scan) begin
				// rotate; once the scan is through, the sample is back in place
				sample_q <= {sample_q[W-2:0], sample_q[W-1]};
			end
			if (ctrl.setup) begin
				alive_q  <= in_win;
				center_q <= at_ctr;
			end else if (ctrl.scan) begin
				// drop out when some candidate has a one where this one has a zero
				alive_q <= alive_q & (sample_q[W-1] | ~any_cand);
			end
		end
	end

	assign sample    = sample_q;
	assign cand_bit  = alive_q & sample_q[W-1];
	assign ctr_bit   = center_q & sample_q[W-1];
	assign is_center = center_q;

endmodule

// ===== sv/wppf_div.sv =====
// ---------------------------------------------------------------------------
// wppf_div
// Restoring divider, one quotient bit per cycle:
// quotient = floor(dividend * 2^QUOT_W / divisor), dividend < divisor.
// ---------------------------------------------------------------------------
module wppf_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [wppf_pkg::SAMPLE_W-1:0] dividend,
	input  logic [wppf_pkg::SAMPLE_W-1:0] divisor,
	output logic                          done,
	output logic [wppf_pkg::QUOT_W-1:0]   quotient
);

	localparam int W  = wppf_pkg::SAMPLE_W;
	localparam int QW = wppf_pkg::QUOT_W;
	localparam int CW = $clog2(QW);
	localparam logic [CW-1:0] CNT_LAST = CW'(QW - 1);

	logic [W-1:0]  rem_q;
	logic [QW-1:0] quot_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [W:0]    trial;
	logic          fits;

	assign trial = {rem_q, 1'b0};
	assign fits  = (trial >= {1'b0, divisor});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == CNT_LAST) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			cnt_q <= '0;
		end else if (busy_q) begin
			// remainder stays below the divisor, so W bits hold it
			rem_q  <= fits ? W'(trial - {1'b0, divisor}) : W'(trial);
			quot_q <= {quot_q[QW-2:0], fits};
			cnt_q  <= cnt_q + 1'b1;
		end
	end

	assign done     = done_q;
	assign quotient = quot_q;

endmodule

// ===== sv/window_peak_prominence_filter.sv =====
// ---------------------------------------------------------------------------
// window_peak_prominence_filter
// Scores each sample by how far it stands above its neighbors on both sides.
// ---------------------------------------------------------------------------
// The block holds the last 2*MAX_NEIGHBORS+1 samples in a row of cells and
// works on one sample at a time. A sample that yields no result frees the
// input again on the next cycle. Each result passes through a setup state,
// an MSB-first maximum search across the cells (one bit per cycle), a
// compare state, the restoring divider when the sample is a peak over a
// nonzero neighbor maximum, and a push state that loads the output register
// once it is free (a peak over all-zero neighbors scores 1.0 without the
// divider). A sample marked end_of_stream produces up to N+1 results back to
// back and then empties the window. The output register lets a result wait
// while the next sample is taken.
// ---------------------------------------------------------------------------
module window_peak_prominence_filter #(
	parameter int MAX_NEIGHBORS = wppf_pkg::MAX_NEIGHBORS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	wppf_cfg_if.sink         cfg_ch,
	wppf_sample_if.sink      sample_ch,
	wppf_result_if.source    result_ch
);

	`include "window_peak_prominence_filter_macros.svh"

	localparam int W      = wppf_pkg::SAMPLE_W;
	localparam int CFGW   = wppf_pkg::CFG_W;
	localparam int DEPTH  = 2 * MAX_NEIGHBORS + 1;
	localparam int NW     = $clog2(MAX_NEIGHBORS + 1);
	localparam int IW     = $clog2(DEPTH);
	localparam int FILL_W = $clog2(DEPTH + 1);
	localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(DEPTH);
	localparam logic [CFGW-1:0]   CFG_MAXN = CFGW'(MAX_NEIGHBORS);

	wppf_pkg::state_t     state_q, state_d;
	wppf_pkg::cell_ctrl_t cell_ctrl;

	logic [CFGW-1:0]   neighbors_q;
	logic [FILL_W-1:0] fill_q;
	logic [FILL_W-1:0] fill_next;
	logic [NW-1:0]     n_eff;
	logic [NW-1:0]     c_start;
	logic [NW-1:0]     n_q;
	logic [NW-1:0]     c_q;
	logic              last_q;
	logic [wppf_pkg::BIT_CNT_W-1:0] bit_cnt_q;
	logic [W-1:0]      m_q;
	logic [W-1:0]      v_q;
	logic [W-1:0]      res_q;
	logic              out_valid_q;
	logic [W-1:0]      score_q;
	logic              final_q;

	logic              sample_ready;
	logic              accept;
	logic              has_result;
	logic              push_ok;
	logic              is_peak;
	logic              full_score;
	logic              div_start;
	logic              div_done;
	logic [wppf_pkg::QUOT_W-1:0] div_quot;

	logic [W-1:0]      prev [DEPTH];
	logic [W-1:0]      win  [DEPTH];
	logic [DEPTH-1:0]  cand_bits;
	logic [DEPTH-1:0]  ctr_bits;
	logic [DEPTH-1:0]  center_flags;
	logic              any_cand;
	logic              ctr_bit;

	// ---- configuration -----------------------------------------------------
	assign cfg_ch.ready = 1'b1;

	always_comb begin
		logic [CFGW-1:0] raw;
		raw = neighbors_q;
		if (raw == '0) begin
			raw = CFGW'(1);
		end else if (raw > CFG_MAXN) begin
			raw = CFG_MAXN;
		end
		n_eff = NW'(raw);
	end

	// ---- item bookkeeping --------------------------------------------------
	assign accept    = sample_ch.valid && sample_ready;
	assign fill_next = (fill_q == FILL_MAX) ? fill_q : fill_q + 1'b1;
	assign has_result = sample_ch.end_of_stream || (fill_next > FILL_W'(n_eff));
	// final sample: start at N back, or at the stream start if it is nearer
	assign c_start   = (!sample_ch.end_of_stream || FILL_W'(n_eff) < fill_next) ?
		n_eff : NW'(fill_next - 1'b1);
	assign push_ok   = !out_valid_q || result_ch.ready;
	assign is_peak    = (v_q > m_q);
	// all-zero neighbors: the ratio is exactly 1.0, skip the divider
	assign full_score = (m_q == '0);

	always_comb begin
		state_d      = state_q;
		cell_ctrl    = '0;
		div_start    = 1'b0;
		sample_ready = 1'b0;
		case (state_q)
			wppf_pkg::ST_IDLE: begin
				sample_ready = 1'b1;
				if (accept) begin
					cell_ctrl.shift = 1'b1;
					if (has_result) begin
						state_d = wppf_pkg::ST_SETUP;
					end
				end
			end
			wppf_pkg::ST_SETUP: begin
				cell_ctrl.setup = 1'b1;
				state_d         = wppf_pkg::ST_SCAN;
			end
			wppf_pkg::ST_SCAN: begin
				cell_ctrl.scan = 1'b1;
				if (bit_cnt_q == wppf_pkg::BIT_LAST) begin
					state_d = wppf_pkg::ST_CMP;
				end
			end
			wppf_pkg::ST_CMP: begin
				if (is_peak && !full_score) begin
					div_start = 1'b1;
					state_d   = wppf_pkg::ST_DIV;
				end else begin
					state_d = wppf_pkg::ST_PUSH;
				end
			end
			wppf_pkg::ST_DIV: begin
				if (div_done) begin
					state_d = wppf_pkg::ST_PUSH;
				end
			end
			wppf_pkg::ST_PUSH: begin
				if (push_ok) begin
					if (last_q && c_q != '0) begin
						state_d = wppf_pkg::ST_SETUP;
					end else begin
						state_d = wppf_pkg::ST_IDLE;
						// end of stream: empty the window for the next one
						cell_ctrl.clear = last_q;
					end
				end
			end
			default: begin
				state_d = wppf_pkg::ST_IDLE;
			end
		endcase
	end

	assign sample_ch.ready = sample_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= wppf_pkg::ST_IDLE;
			neighbors_q <= wppf_pkg::NEIGHBORS_RESET;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_ch.valid) begin
				neighbors_q <= cfg_ch.neighbors;
			end
			if (accept) begin
				fill_q <= fill_next;
			end else if (cell_ctrl.clear) begin
				fill_q <= '0;
			end
			if (state_q == wppf_pkg::ST_PUSH && push_ok) begin
				out_valid_q <= 1'b1;
			end else if (result_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			n_q    <= n_eff;
			c_q    <= c_start;
			last_q <= sample_ch.end_of_stream;
		end
		if (cell_ctrl.setup) begin
			bit_cnt_q <= '0;
		end else if (cell_ctrl.scan) begin
			bit_cnt_q <= bit_cnt_q + 1'b1;
			m_q       <= {m_q[W-2:0], any_cand};
			v_q       <= {v_q[W-2:0], ctr_bit};
		end
		if (state_q == wppf_pkg::ST_CMP) begin
			res_q <= is_peak ? wppf_pkg::SCORE_ONE : '0;
		end
		if (state_q == wppf_pkg::ST_DIV && div_done) begin
			res_q <= {1'b0, div_quot};
		end
		if (state_q == wppf_pkg::ST_PUSH && push_ok) begin
			score_q <= res_q;
			final_q <= last_q && (c_q == '0);
			if (last_q && c_q != '0) begin
				c_q <= c_q - 1'b1;
			end
		end
	end

	// ---- cell row ----------------------------------------------------------
	assign prev[0] = sample_ch.sample;

	for (genvar k = 0; k < DEPTH; k++) begin : g_cell
		if (k > 0) begin : g_link
			assign prev[k] = win[k-1];
		end
		wppf_cell #(
			.IDX (k),
			.NW  (NW),
			.IW  (IW)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (cell_ctrl),
			.prev_sample (prev[k]),
			.center      (c_q),
			.nbr         (n_q),
			.any_cand    (any_cand),
			.sample      (win[k]),
			.cand_bit    (cand_bits[k]),
			.ctr_bit     (ctr_bits[k]),
			.is_center   (center_flags[k])
		);
	end

	assign any_cand = |cand_bits;
	assign ctr_bit  = |ctr_bits;

	// ---- divider -----------------------------------------------------------
	wppf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (v_q - m_q),
		.divisor  (v_q),
		.done     (div_done),
		.quotient (div_quot)
	);

	// ---- result channel ----------------------------------------------------
	assign result_ch.valid     = out_valid_q;
	assign result_ch.score     = score_q;
	assign result_ch.final_res = final_q;

	// ---- checks ------------------------------------------------------------
	`WPPF_ASSERT(a_center_onehot, (state_q == wppf_pkg::ST_SCAN) |-> $onehot(center_flags))
	`WPPF_ASSERT(a_div_done_in_div, div_done |-> (state_q == wppf_pkg::ST_DIV))
	`WPPF_NEVER(a_score_range, out_valid_q && (score_q > wppf_pkg::SCORE_ONE))
	`WPPF_ASSERT(a_flush_clears, cell_ctrl.clear |=> (fill_q == '0))

endmodule
